/* rtl/core/url_path_normalizer_assert.svh */
// assertion macros for the url path normalizer rtl
`ifndef URL_PATH_NORMALIZER_ASSERT_SVH
`define URL_PATH_NORMALIZER_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define UPN_ASSERT_NOW(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) else $error(msg);

// condition holds in the cycle after the trigger
`define UPN_ASSERT_NEXT(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) else $error(msg);

`endif

/* rtl/core/upn_pkg.sv */
// shared constants, types and helpers for the url path normalizer
`timescale 1ns / 1ps

package upn_pkg;

   localparam int STORE_SIZE = 8192;
   localparam int MAX_DEPTH  = 256;
   localparam int MAX_PATH   = 65535;

   localparam int OUT_AW  = $clog2(STORE_SIZE);   // store address width
   localparam int BANK_AW = OUT_AW - 1;           // even/odd bank address width
   localparam int STK_AW  = $clog2(MAX_DEPTH);    // stack address width
   localparam int DEP_W   = STK_AW + 1;           // depth counter, holds MAX_DEPTH
   localparam int WP_W    = 17;                   // write pointer, up to path length + 1
   localparam int POS_W   = 16;                   // byte position, holds MAX_PATH
   localparam int IDX_W   = 13;                   // read index field
   localparam int LEN_W   = 13;                   // length field

   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_NUL   = 8'h00;

   // error flag bit positions
   localparam int ERR_NO_LEAD = 0;
   localparam int ERR_NUL     = 1;
   localparam int ERR_ROOT    = 2;
   localparam int ERR_DEEP    = 3;
   localparam int ERR_LONG    = 4;
   localparam int ERR_W       = 5;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NO_LEAD    = 3'd1,
      ST_NUL        = 3'd2,
      ST_ABOVE_ROOT = 3'd3,
      ST_TOO_DEEP   = 3'd4,
      ST_TOO_LONG   = 3'd5
   } status_type;

   typedef enum logic {
      ACT_PATH_BYTE = 1'b0,
      ACT_READ      = 1'b1
   } action_type;

   typedef enum logic {
      KIND_STATUS = 1'b0,
      KIND_DATA   = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      status_type        status;
      logic [LEN_W-1:0]  norm_length;
      logic [7:0]        data_byte;
   } rsp_item_type;

   // lowest set flag wins
   function automatic status_type status_of(input logic [ERR_W-1:0] flags);
      status_type st;
      st = ST_OK;
      if (flags[ERR_NO_LEAD])   st = ST_NO_LEAD;
      else if (flags[ERR_NUL])  st = ST_NUL;
      else if (flags[ERR_ROOT]) st = ST_ABOVE_ROOT;
      else if (flags[ERR_DEEP]) st = ST_TOO_DEEP;
      else if (flags[ERR_LONG]) st = ST_TOO_LONG;
      return st;
   endfunction

endpackage

/* rtl/core/url_path_normalizer.sv */
// url path normalizer: dot-segment removal and slash collapsing over a byte stream
//
// One request beat carries either a path byte (tuser = 0, tlast on the final byte) or a read of
// the normalized store (tuser = 1). Path bytes run at one beat per cycle while the result queue
// has room: every byte does constant work against registered segment state, and the top of the
// segment stack is kept ready by reading the stack memory every cycle at the next depth, with a
// bypass for a push made in the same cycle. A kept segment writes a slash and its first byte in
// one beat, so the output store is split into an even and an odd byte bank, each with one write
// port. The final byte produces one status beat; a read produces one data beat. Results pass
// through the store read register, then a three-entry result queue, and the request side keeps
// accepting while up to two finished results wait on a stalled response side. The store and the
// stack are undefined after reset and need no clearing pass; per-path state clears on reset and
// after every status beat, while the store and the last normalized length survive for reads.
`timescale 1ns / 1ps

module url_path_normalizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // path_byte [7:0], read_index [20:8], zero [23:21]
   input  logic        req_tlast,   // last byte of the path
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // status [2:0], norm_length [15:3], data_byte [23:16]
   output logic        rsp_tuser    // kind
);
   import upn_pkg::*;

   localparam int FIFO_DEPTH = 3;
   localparam int FP_W       = 2;

   // request fields
   logic [7:0]       req_byte;
   logic [IDX_W-1:0] req_index;
   action_type       req_action;
   logic             req_acc;
   logic             path_acc;
   logic             read_acc;

   assign req_byte   = req_tdata[7:0];
   assign req_index  = req_tdata[IDX_W+7:8];
   assign req_action = action_type'(req_tuser);
   assign req_acc    = req_tvalid && req_tready;
   assign path_acc   = req_acc && (req_action == ACT_PATH_BYTE);
   assign read_acc   = req_acc && (req_action == ACT_READ);

   // per-path state
   logic [DEP_W-1:0] depth_ff, depth_in;
   logic [WP_W-1:0]  wp_ff, wp_in;
   logic [WP_W-1:0]  seg_start_ff, seg_start_in;
   logic [POS_W-1:0] seg_len_ff, seg_len_in;
   logic             all_dots_ff, all_dots_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [ERR_W-1:0] err_ff, err_in;
   logic [LEN_W-1:0] final_len_ff, final_len_in;

   // segment stack memory, top kept readable through a registered read plus push bypass
   logic [WP_W-1:0]   stk_mem [MAX_DEPTH];
   logic [WP_W-1:0]   stk_rd_ff;
   logic              byp_ff, byp_in;
   logic [WP_W-1:0]   byp_data_ff;
   logic [STK_AW-1:0] stk_raddr;
   logic [WP_W-1:0]   stk_top;

   // output store, even and odd byte banks
   logic [7:0]         even_mem [STORE_SIZE/2];
   logic [7:0]         odd_mem  [STORE_SIZE/2];
   logic [7:0]         rd_even_ff, rd_odd_ff;
   logic               even_we, odd_we;
   logic [BANK_AW-1:0] even_addr, odd_addr;
   logic [7:0]         even_data, odd_data;

   // per-beat working values
   logic [ERR_W-1:0] err_v;
   logic [POS_W-1:0] pos_v;
   logic [DEP_W-1:0] d_v;
   logic [WP_W-1:0]  wp_v;
   logic [WP_W-1:0]  ss_v;
   logic [POS_W-1:0] sl_v;
   logic             ad_v;
   logic             counted;
   logic             frozen;
   logic             slash_we;
   logic             byte_we;
   logic [WP_W-1:0]  byte_addr;
   logic             push;
   logic             root_we;
   status_type       status_v;
   logic [LEN_W-1:0] len_v;

   assign stk_top = byp_ff ? byp_data_ff : stk_rd_ff;

   always_comb begin
      err_v     = err_ff;
      pos_v     = pos_ff;
      d_v       = depth_ff;
      wp_v      = wp_ff;
      ss_v      = seg_start_ff;
      sl_v      = seg_len_ff;
      ad_v      = all_dots_ff;
      counted   = 1'b1;
      slash_we  = 1'b0;
      byte_we   = 1'b0;
      byte_addr = wp_ff;
      push      = 1'b0;
      root_we   = 1'b0;
      status_v  = ST_OK;
      len_v     = '0;

      // position bookkeeping, bytes past the path limit are only flagged
      if (pos_ff >= POS_W'(MAX_PATH)) begin
         err_v[ERR_LONG] = 1'b1;
         counted         = 1'b0;
      end else begin
         if (pos_ff == '0 && req_byte != CH_SLASH) err_v[ERR_NO_LEAD] = 1'b1;
         pos_v = pos_ff + POS_W'(1);
      end
      if (req_byte == CH_NUL) err_v[ERR_NUL] = 1'b1;

      frozen = err_v[ERR_ROOT] | err_v[ERR_DEEP];

      // append a byte, opening the segment with a slash
      if (counted && !frozen && req_byte != CH_SLASH) begin
         if (sl_v == '0) begin
            ss_v     = wp_v;
            slash_we = 1'b1;
            wp_v     = wp_v + WP_W'(1);
         end
         byte_addr = wp_v;
         byte_we   = 1'b1;
         wp_v      = wp_v + WP_W'(1);
         sl_v      = sl_v + POS_W'(1);
         if (req_byte != CH_DOT) ad_v = 1'b0;
      end

      // close the open segment on a slash or at the end of the path
      if (!frozen && ((counted && req_byte == CH_SLASH) || req_tlast) && sl_v != '0) begin
         if (ad_v && sl_v == POS_W'(1)) begin
            wp_v = ss_v;
         end else if (ad_v && sl_v == POS_W'(2)) begin
            if (d_v == '0) begin
               err_v[ERR_ROOT] = 1'b1;
            end else begin
               d_v  = d_v - DEP_W'(1);
               wp_v = stk_top;
            end
         end else if (d_v >= DEP_W'(MAX_DEPTH)) begin
            err_v[ERR_DEEP] = 1'b1;
         end else begin
            push = 1'b1;
            d_v  = d_v + DEP_W'(1);
         end
         sl_v = '0;
         ad_v = 1'b1;
      end

      // end of path: empty result becomes root, then length check and status
      if (req_tlast) begin
         if (!(err_v[ERR_ROOT] | err_v[ERR_DEEP])) begin
            if (d_v == '0) begin
               root_we = 1'b1;
               wp_v    = WP_W'(1);
            end
            if (wp_v >= WP_W'(STORE_SIZE)) err_v[ERR_LONG] = 1'b1;
         end
         status_v = status_of(err_v);
         len_v    = (status_v == ST_OK) ? wp_v[LEN_W-1:0] : '0;
      end
   end

   // next state, per-path state restarts after the final byte
   always_comb begin
      depth_in     = depth_ff;
      wp_in        = wp_ff;
      seg_start_in = seg_start_ff;
      seg_len_in   = seg_len_ff;
      all_dots_in  = all_dots_ff;
      pos_in       = pos_ff;
      err_in       = err_ff;
      final_len_in = final_len_ff;
      if (path_acc) begin
         if (req_tlast) begin
            depth_in     = '0;
            wp_in        = '0;
            seg_start_in = '0;
            seg_len_in   = '0;
            all_dots_in  = 1'b1;
            pos_in       = '0;
            err_in       = '0;
            final_len_in = len_v;
         end else begin
            depth_in     = d_v;
            wp_in        = wp_v;
            seg_start_in = ss_v;
            seg_len_in   = sl_v;
            all_dots_in  = ad_v;
            pos_in       = pos_v;
            err_in       = err_v;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         wp_ff        <= '0;
         seg_start_ff <= '0;
         seg_len_ff   <= '0;
         all_dots_ff  <= 1'b1;
         pos_ff       <= '0;
         err_ff       <= '0;
         final_len_ff <= '0;
         byp_ff       <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         wp_ff        <= wp_in;
         seg_start_ff <= seg_start_in;
         seg_len_ff   <= seg_len_in;
         all_dots_ff  <= all_dots_in;
         pos_ff       <= pos_in;
         err_ff       <= err_in;
         final_len_ff <= final_len_in;
         byp_ff       <= byp_in;
      end
   end

   // stack: push at the old depth, read the entry under the new depth every cycle
   assign byp_in    = path_acc && push;
   assign stk_raddr = depth_in[STK_AW-1:0] - STK_AW'(1);

   always_ff @(posedge clock) begin
      if (path_acc && push) stk_mem[depth_ff[STK_AW-1:0]] <= ss_v;
      stk_rd_ff   <= stk_mem[stk_raddr];
      byp_data_ff <= ss_v;
   end

   // store writes: slash and byte land on consecutive addresses, so on different banks
   always_comb begin
      even_we   = 1'b0;
      odd_we    = 1'b0;
      even_addr = '0;
      odd_addr  = '0;
      even_data = CH_SLASH;
      odd_data  = CH_SLASH;
      if (path_acc) begin
         if (root_we) begin
            // only the root slash is visible after this path
            even_we = 1'b1;
         end else begin
            if (slash_we && wp_ff < WP_W'(STORE_SIZE)) begin
               if (wp_ff[0]) begin
                  odd_we   = 1'b1;
                  odd_addr = wp_ff[OUT_AW-1:1];
               end else begin
                  even_we   = 1'b1;
                  even_addr = wp_ff[OUT_AW-1:1];
               end
            end
            if (byte_we && byte_addr < WP_W'(STORE_SIZE)) begin
               if (byte_addr[0]) begin
                  odd_we   = 1'b1;
                  odd_addr = byte_addr[OUT_AW-1:1];
                  odd_data = req_byte;
               end else begin
                  even_we   = 1'b1;
                  even_addr = byte_addr[OUT_AW-1:1];
                  even_data = req_byte;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (even_we) even_mem[even_addr] <= even_data;
      if (read_acc) rd_even_ff <= even_mem[req_index[OUT_AW-1:1]];
   end

   always_ff @(posedge clock) begin
      if (odd_we) odd_mem[odd_addr] <= odd_data;
      if (read_acc) rd_odd_ff <= odd_mem[req_index[OUT_AW-1:1]];
   end

   // result stage alongside the store read
   logic             p1_valid_ff, p1_valid_in;
   kind_type         p1_kind_ff;
   status_type       p1_status_ff;
   logic [LEN_W-1:0] p1_len_ff;
   logic             p1_hit_ff;
   logic             p1_odd_ff;
   rsp_item_type     p1_item;

   assign p1_valid_in = path_acc ? req_tlast : read_acc;

   always_ff @(posedge clock) begin
      if (reset) p1_valid_ff <= 1'b0;
      else       p1_valid_ff <= p1_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         p1_kind_ff   <= read_acc ? KIND_DATA : KIND_STATUS;
         p1_status_ff <= read_acc ? ST_OK : status_v;
         p1_len_ff    <= read_acc ? final_len_ff : len_v;
         p1_hit_ff    <= req_index < final_len_ff;
         p1_odd_ff    <= req_index[0];
      end
   end

   always_comb begin
      p1_item.kind        = p1_kind_ff;
      p1_item.status      = p1_status_ff;
      p1_item.norm_length = p1_len_ff;
      p1_item.data_byte   = 8'h00;
      if (p1_kind_ff == KIND_DATA && p1_hit_ff) begin
         p1_item.data_byte = p1_odd_ff ? rd_odd_ff : rd_even_ff;
      end
   end

   // result queue, room is reserved before a beat is accepted
   rsp_item_type    fifo_mem_ff [FIFO_DEPTH];
   logic [FP_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FP_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FP_W-1:0] cnt_ff, cnt_in;
   logic            fifo_pop;
   rsp_item_type    rsp_item;

   assign fifo_pop   = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = cnt_ff != '0;
   assign req_tready = ({1'b0, cnt_ff} + {2'b00, p1_valid_ff}) < 3'(FIFO_DEPTH);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (p1_valid_ff) begin
         wr_ptr_in = (wr_ptr_ff == FP_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + FP_W'(1);
      end
      if (fifo_pop) begin
         rd_ptr_in = (rd_ptr_ff == FP_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + FP_W'(1);
      end
      if (p1_valid_ff && !fifo_pop)      cnt_in = cnt_ff + FP_W'(1);
      else if (!p1_valid_ff && fifo_pop) cnt_in = cnt_ff - FP_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (p1_valid_ff) fifo_mem_ff[wr_ptr_ff] <= p1_item;
   end

   assign rsp_item  = fifo_mem_ff[rd_ptr_ff];
   assign rsp_tuser = rsp_item.kind;
   assign rsp_tdata = {rsp_item.data_byte, rsp_item.norm_length, rsp_item.status};

   // checks
   `include "url_path_normalizer_assert.svh"

   `UPN_ASSERT_NEXT(a_path_restart, path_acc && req_tlast,
                    depth_ff == '0 && pos_ff == '0 && err_ff == '0,
                    "per-path state not cleared after final byte")
   `UPN_ASSERT_NEXT(a_read_result, read_acc, p1_valid_ff && p1_kind_ff == KIND_DATA,
                    "read beat did not produce a data result")
   `UPN_ASSERT_NOW(a_fifo_room, cnt_ff == FP_W'(FIFO_DEPTH), !p1_valid_ff,
                   "result queue overflow")

endmodule

/* tb/testbench.sv */
// self-checking stream testbench for the url path normalizer with its own path predictor
`timescale 1ns / 1ps

module testbench;
   import upn_pkg::*;

   // watchdog and pacing
   localparam int WATCHDOG_LIMIT  = 3000;   // cycles with no beat moving while work is owed
   localparam int RSP_HOLD_CYCLES = 300;    // long receiver hold-off, fills the result queue
   localparam int SETTLE_CYCLES   = 16;     // margin over the block latency before the end check
   localparam int QUIET_TAIL      = 250;    // last beats go out with no idling on either side
   localparam int RANDOM_BEATS    = 600;
   localparam int MAX_REPORTS     = 10;

   // one request beat as the stimulus sees it
   typedef struct {
      action_type        act;
      logic [7:0]        ch;
      bit                fin;
      logic [IDX_W-1:0]  idx;
      bit                drain;      // hold this beat back until all results are in
      bit                hold_rsp;   // receiver holds off once this beat is taken
   } req_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;     // path_byte [7:0], read_index [20:8], zero [23:21]
   logic        req_tlast = 1'b0;   // last byte of the path
   logic        req_tuser = 1'b0;   // action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;          // status [2:0], norm_length [15:3], data_byte [23:16]
   logic        rsp_tuser;          // kind

   url_path_normalizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stimulus backlog, results owed by the block, bookkeeping
   req_beat_type request_backlog[$];
   rsp_item_type owed_results[$];
   req_beat_type on_wire;
   bit           drain_next = 1'b0;
   int unsigned  failures = 0;
   int unsigned  send_gap = 0;
   int unsigned  take_gap = 0;
   int unsigned  hold_left = 0;
   int unsigned  idle_watch = 0;
   logic         quiet_phase = 1'b0;
   logic         hold_request = 1'b0;

   // ------------------------------------------------------------------
   // path normalizer mirror: store, segment stack and per-path state
   // ------------------------------------------------------------------
   logic [7:0]       mirror_store [STORE_SIZE];
   int unsigned      kept_starts [MAX_DEPTH];
   int unsigned      seg_depth, wr_ptr, seg_begin, seg_len, path_pos, last_length;
   bit               seg_dots;
   logic [ERR_W-1:0] err_flags;

   function automatic void restart_path();
      seg_depth = 0;
      wr_ptr    = 0;
      seg_begin = 0;
      seg_len   = 0;
      seg_dots  = 1'b1;
      path_pos  = 0;
      err_flags = '0;
   endfunction

   // bytes past the end of the store are counted but dropped
   function automatic void store_byte(input int unsigned at, input logic [7:0] v);
      if (at < STORE_SIZE) mirror_store[at] = v;
   endfunction

   // a slash or the end of the path closes the open segment
   function automatic void close_segment();
      if (seg_len == 0) return;
      if (seg_dots && seg_len == 1) begin
         // single dot: drop what was written for it
         wr_ptr = seg_begin;
      end else if (seg_dots && seg_len == 2) begin
         // double dot: pop the last kept segment, or climb above root
         if (seg_depth == 0) begin
            err_flags[ERR_ROOT] = 1'b1;
         end else begin
            seg_depth--;
            wr_ptr = kept_starts[seg_depth];
         end
      end else if (seg_depth >= MAX_DEPTH) begin
         err_flags[ERR_DEEP] = 1'b1;
      end else begin
         kept_starts[seg_depth] = seg_begin;
         seg_depth++;
      end
      seg_len  = 0;
      seg_dots = 1'b1;
   endfunction

   // advance the mirror by one accepted beat, returns 1 when a result is due
   function automatic bit normalize_beat(input req_beat_type b, output rsp_item_type r);
      bit counted;
      int k;
      r = '0;
      if (b.act == ACT_READ) begin
         r.kind        = KIND_DATA;
         r.status      = ST_OK;
         r.norm_length = last_length[LEN_W-1:0];
         r.data_byte   = (b.idx < last_length) ? mirror_store[b.idx] : 8'h00;
         return 1'b1;
      end
      counted = 1'b1;
      if (path_pos >= MAX_PATH) begin
         // overlong path: only the nul check and the end flag still matter
         err_flags[ERR_LONG] = 1'b1;
         counted = 1'b0;
      end else begin
         if (path_pos == 0 && b.ch != CH_SLASH) err_flags[ERR_NO_LEAD] = 1'b1;
         path_pos++;
      end
      if (b.ch == CH_NUL) err_flags[ERR_NUL] = 1'b1;
      // segment logic freezes after an above-root or depth error
      if (counted && !err_flags[ERR_ROOT] && !err_flags[ERR_DEEP]) begin
         if (b.ch == CH_SLASH) begin
            close_segment();
         end else begin
            if (seg_len == 0) begin
               seg_begin = wr_ptr;
               store_byte(wr_ptr, CH_SLASH);
               wr_ptr++;
            end
            store_byte(wr_ptr, b.ch);
            wr_ptr++;
            seg_len++;
            if (b.ch != CH_DOT) seg_dots = 1'b0;
         end
      end
      if (!b.fin) return 1'b0;
      if (!err_flags[ERR_ROOT] && !err_flags[ERR_DEEP]) close_segment();
      if (!err_flags[ERR_ROOT] && !err_flags[ERR_DEEP]) begin
         // empty result is the root slash; a result must stay below the store size
         if (seg_depth == 0) begin
            store_byte(0, CH_SLASH);
            wr_ptr = 1;
         end
         if (wr_ptr >= STORE_SIZE) err_flags[ERR_LONG] = 1'b1;
      end
      r.kind   = KIND_STATUS;
      r.status = ST_OK;
      // lowest set flag decides the status
      for (k = ERR_W - 1; k >= 0; k--)
         if (err_flags[k]) r.status = status_type'(k + 1);
      last_length   = (r.status == ST_OK) ? wr_ptr : 0;
      r.norm_length = last_length[LEN_W-1:0];
      restart_path();
      return 1'b1;
   endfunction

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
   endfunction

   // ------------------------------------------------------------------
   // stimulus building
   // ------------------------------------------------------------------
   task automatic queue_beat(input req_beat_type b);
      b.drain    = drain_next;
      drain_next = 1'b0;
      request_backlog.push_back(b);
   endtask

   task automatic push_byte(input logic [7:0] ch, input bit fin);
      req_beat_type b;
      b.act      = ACT_PATH_BYTE;
      b.ch       = ch;
      b.fin      = fin;
      b.idx      = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
      b.hold_rsp = 1'b0;
      queue_beat(b);
   endtask

   // read beats carry random byte and tlast, both ignored by the block
   task automatic push_read(input logic [IDX_W-1:0] idx, input bit hold);
      req_beat_type b;
      b.act      = ACT_READ;
      b.ch       = 8'($urandom_range(0, 255));
      b.fin      = 1'($urandom_range(0, 1));
      b.idx      = idx;
      b.hold_rsp = hold;
      queue_beat(b);
   endtask

   task automatic push_text(input string s, input bit fin);
      int k;
      for (k = 0; k < s.len(); k++) push_byte(s[k], fin && (k == s.len() - 1));
   endtask

   // n one-letter segments, one stack entry each
   task automatic push_chain(input int n, input logic [7:0] letter);
      int k;
      for (k = 0; k < n; k++) begin
         push_byte(CH_SLASH, 1'b0);
         push_byte(letter, k == n - 1);
      end
   endtask

   function automatic logic [7:0] pick_byte(input bit allow_nul);
      logic [7:0] v;
      do v = 8'($urandom_range(0, 255));
      while (v == CH_SLASH || (!allow_nul && v == CH_NUL));
      return v;
   endfunction

   // mostly within short results, sometimes anywhere, sometimes at the top of the store
   function automatic logic [IDX_W-1:0] pick_index();
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4: return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
         5, 6, 7:       return IDX_W'($urandom_range(STORE_SIZE - 12, STORE_SIZE - 1));
         default:       return IDX_W'($urandom_range(0, 48));
      endcase
   endfunction

   // random path; clean paths stay above root, noisy ones break the rules
   task automatic push_random_path(input bit clean);
      logic [7:0] text[$];
      int unsigned segs, s, n, k, depth_guess;
      depth_guess = 0;
      if (clean || $urandom_range(0, 3) != 0) text.push_back(CH_SLASH);
      else text.push_back(pick_byte(1'b1));
      segs = $urandom_range(0, 6);
      for (s = 0; s < segs; s++) begin
         if (s != 0 || $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) text.push_back(CH_SLASH);
         case ($urandom_range(0, 7))
            0: text.push_back(CH_DOT);
            1: begin
               if (clean && depth_guess == 0) begin
                  text.push_back(8'(8'h61 + $urandom_range(0, 25)));
                  depth_guess++;
               end else begin
                  text.push_back(CH_DOT);
                  text.push_back(CH_DOT);
                  if (depth_guess != 0) depth_guess--;
               end
            end
            2: begin
               repeat (3) text.push_back(CH_DOT);
               depth_guess++;
            end
            3, 4, 5: begin
               n = $urandom_range(1, 4);
               repeat (n) text.push_back(8'(8'h61 + $urandom_range(0, 25)));
               depth_guess++;
            end
            default: begin
               n = $urandom_range(1, 3);
               repeat (n) text.push_back(pick_byte(!clean));
               depth_guess++;
            end
         endcase
      end
      if ($urandom_range(0, 3) == 0) text.push_back(CH_SLASH);
      if (!clean) begin
         if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) begin
               text.push_back(CH_SLASH);
               text.push_back(CH_DOT);
               text.push_back(CH_DOT);
            end
         if ($urandom_range(0, 2) == 0) text[$urandom_range(0, text.size() - 1)] = CH_NUL;
      end
      // occasional reads land in the middle of a path
      for (k = 0; k < text.size(); k++) begin
         if ($urandom_range(0, 24) == 0) push_read(pick_index(), 1'b0);
         push_byte(text[k], k == text.size() - 1);
      end
   endtask

   // ------------------------------------------------------------------
   // driver: one beat on the request side, held until taken
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_item_type outcome;
      bit fire, holds;
      if (reset) begin
         req_tvalid   <= 1'b0;
         hold_request <= 1'b0;
         quiet_phase  <= 1'b0;
         send_gap     = 0;
      end else begin
         fire  = req_tvalid && req_tready;
         holds = fire && on_wire.hold_rsp;
         if (fire && normalize_beat(on_wire, outcome)) owed_results.push_back(outcome);
         if (req_tvalid && !fire) begin
            // beat stays on the bus until taken
         end else if (send_gap != 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (request_backlog.size() == 0 ||
                      (!quiet_phase && request_backlog[0].drain &&
                       owed_results.size() != 0)) begin
            req_tvalid <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
            // idle burst of random length, this cycle included
            send_gap = $urandom_range(0, 7);
            req_tvalid <= 1'b0;
         end else begin
            on_wire = request_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {3'b000, on_wire.idx, on_wire.ch};
            req_tlast  <= on_wire.fin;
            req_tuser  <= on_wire.act;
         end
         hold_request <= holds;
         quiet_phase  <= (request_backlog.size() < QUIET_TAIL);
      end
   end

   // ------------------------------------------------------------------
   // monitor: result beats checked field by field, ready paced at random
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_item_type seen, want;
      if (reset) begin
         rsp_tready <= 1'b0;
         take_gap  = 0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.kind        = kind_type'(rsp_tuser);
            seen.status      = status_type'(rsp_tdata[2:0]);
            seen.norm_length = rsp_tdata[15:3];
            seen.data_byte   = rsp_tdata[23:16];
            if (owed_results.size() == 0) begin
               note_failure($sformatf({"result beat with none owed: ",
                            "kind %0d status %0d len %0d byte %02h"},
                            seen.kind, seen.status, seen.norm_length, seen.data_byte));
            end else begin
               want = owed_results.pop_front();
               if (seen.kind !== want.kind || seen.status !== want.status ||
                   seen.norm_length !== want.norm_length || seen.data_byte !== want.data_byte)
                  note_failure($sformatf({"expected kind %0d status %0d len %0d byte %02h, ",
                               "got kind %0d status %0d len %0d byte %02h"},
                               want.kind, want.status, want.norm_length, want.data_byte,
                               seen.kind, seen.status, seen.norm_length, seen.data_byte));
            end
         end
         // long hold-off starts from the registered hold request once the marked beat is taken
         if (hold_request && !quiet_phase) hold_left = RSP_HOLD_CYCLES;
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (take_gap != 0) begin
            take_gap--;
            rsp_tready <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
            take_gap = $urandom_range(0, 7);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog: no beat moving for too long while work is still owed
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_watch <= 0;
      else if (request_backlog.size() != 0 || req_tvalid || owed_results.size() != 0)
         idle_watch <= idle_watch + 1;
      if (idle_watch >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
         $display("simulation failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus plan, reset and end of run
   // ------------------------------------------------------------------
   initial begin
      int unsigned random_goal, pick;
      for (int k = 0; k < STORE_SIZE; k++) mirror_store[k] = 8'h00;
      last_length = 0;
      restart_path();

      // reads before any path: length zero, data zero
      push_read(0, 1'b0);
      push_read((1 << IDX_W) - 1, 1'b0);
      // root, slash collapsing, dot and double dot
      push_text("/", 1'b1);
      push_read(0, 1'b0);
      push_text("//a//b/", 1'b1);
      push_text("/a/./b/../c", 1'b1);
      push_read(2, 1'b0);
      push_text("/a/..", 1'b1);
      // three dots and dotted names are ordinary segments
      push_text("/.../.a/a.", 1'b1);
      push_read(5, 1'b0);
      // high-bit bytes
      push_byte(CH_SLASH, 1'b0);
      push_byte(8'hff, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'h7f, 1'b1);
      push_read(1, 1'b0);
      // errors: above root, no leading slash, nul, and priority among them
      push_text("/..", 1'b1);
      push_text("a", 1'b1);
      push_text("/a", 1'b0);
      push_byte(CH_NUL, 1'b0);
      push_text("b", 1'b1);
      push_text("x/..", 1'b1);
      // nul still seen while the segment logic is frozen
      push_text("/../", 1'b0);
      push_byte(CH_NUL, 1'b1);

      // depth limit: exactly full, then one over
      push_chain(MAX_DEPTH, 8'h71);
      push_read(IDX_W'(2 * MAX_DEPTH - 1), 1'b0);
      push_chain(MAX_DEPTH + 1, 8'h72);

      // receiver stalls long while reads keep coming, then sender drains
      push_read(pick_index(), 1'b1);
      repeat (24) push_read(pick_index(), 1'b0);
      drain_next = 1'b1;
      push_text("/p/q", 1'b1);
      drain_next = 1'b1;

      // random part: mostly clean paths, some broken ones, reads in between
      random_goal = request_backlog.size() + RANDOM_BEATS;
      while (request_backlog.size() < random_goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 64) begin
            push_random_path(1'b1);
         end else if (pick < 78) begin
            push_random_path(1'b0);
         end else if (pick < 97) begin
            repeat ($urandom_range(1, 4)) push_read(pick_index(), 1'b0);
         end else if (pick < 99) begin
            drain_next = 1'b1;
            push_random_path(1'b1);
         end else begin
            push_read(pick_index(), 1'b1);
            repeat (12) push_read(pick_index(), 1'b0);
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (request_backlog.size() != 0 || req_tvalid || owed_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (owed_results.size() != 0)
         note_failure($sformatf("%0d results never arrived", owed_results.size()));
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
